@@ rtl/core/phase_shifter_calibration_defines.svh @@
// ----------------------------------------------------------------------------
// Phase shifter calibration assertion macros
// Shared concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PHASE_SHIFTER_CALIBRATION_DEFINES_SVH
`define PHASE_SHIFTER_CALIBRATION_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/core/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// Phase shifter calibration package
// Sizes, codes and shared types of the calibration block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

  // Table sizes.
  localparam int CHANNELS    = 64;
  localparam int SETS        = 8;
  localparam int BREAKPOINTS = 32;
  localparam int MAP_SIZE    = 512;
  localparam int STRETCH_MAX = 8;
  localparam int ROW_LEN     = STRETCH_MAX + 1;

  // Derived widths.
  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SET_IW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int BPT_DEPTH = 2 * SETS * BREAKPOINTS;
  localparam int BPT_AW    = $clog2(BPT_DEPTH);
  localparam int BP_IW     = $clog2(BREAKPOINTS);
  localparam int BP_CW     = $clog2(BREAKPOINTS + 1);
  localparam int MAP_DEPTH = SETS * MAP_SIZE;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int MAP_IW    = $clog2(MAP_SIZE);
  localparam int MAP_CW    = $clog2(MAP_SIZE + 1);
  localparam int ST_DEPTH  = SETS * CHANNELS * ROW_LEN;
  localparam int ST_AW     = $clog2(ST_DEPTH);
  localparam int ROW_IW    = $clog2(ROW_LEN);
  localparam int ROW_CW    = $clog2(ROW_LEN + 1);
  localparam int SI_W      = (BP_CW > ROW_CW) ? BP_CW : ROW_CW;

  // Fixed field widths.
  localparam int OP_W   = 3;
  localparam int VAL_W  = 16;
  localparam int ATT_W  = 17;
  localparam int PH_W   = 32;
  localparam int STAT_W = 3;
  localparam int SUM_W  = 18;
  localparam int DVD_W  = 34;
  localparam int DVS_W  = 17;
  localparam int IN_TW  = 88;
  localparam int OUT_TW = 56;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 4;

  // Input queue.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PROC    = 3'd0,
    OP_CHAN    = 3'd1,
    OP_ATT     = 3'd2,
    OP_PHASE   = 3'd3,
    OP_MAP     = 3'd4,
    OP_STRETCH = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_ATT    = 3'd1,
    ST_MAP_EMPTY = 3'd2,
    ST_SPAN_ZERO = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ATT_EN  = 2'd0,
    CFG_PH_EN   = 2'd1,
    CFG_STRETCH = 2'd2
  } cfg_e;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [5:0]              channel;
    logic [2:0]              set_idx;
    logic [8:0]              entry;
    logic signed [VAL_W-1:0] att;
    logic signed [VAL_W-1:0] phase;
    logic signed [VAL_W-1:0] val_a;
    logic signed [VAL_W-1:0] val_b;
    logic                    bad;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/core/phase_shifter_calibration.sv @@
// Write item: passes from the queue through the table write and the output register to its result.
// Process item: its duration is set by up to two passes through the shared bit-serial
// divider and by the breakpoint scans (one table entry per cycle); one item is in
// work at a time, two more may queue.
// Reset: configuration, channel entries and table counts clear at once; table
// contents are undefined until written, so no clearing pass is run.
// ----------------------------------------------------------------------------
// Phase shifter calibration
// Per-channel phase and attenuation calibration with table loading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phase_shifter_calibration import psc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // channel, set_index, entry_index, att_value, phase_value, value_a, value_b
  input  logic [IN_TW-1:0]  s_axis_tdata,
  // op
  input  logic [OP_W-1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // phase_out, att_out, status
  output logic [OUT_TW-1:0] m_axis_tdata
);

  item_t    head;
  logic     head_vld, pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  psc_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .head_o(head), .head_vld_o(head_vld), .pop_i(pop)
  );

  psc_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  psc_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .head_i(head), .head_vld_i(head_vld), .pop_o(pop),
    .div_req_o(div_req), .div_rsp_i(div_rsp),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

@@ rtl/core/psc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/psc_front.sv @@
// ----------------------------------------------------------------------------
// Calibration front end
// Accepts input transfers, checks their ranges and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_front import psc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // channel, set_index, entry_index, att_value, phase_value, value_a, value_b
  input  logic [IN_TW-1:0] s_axis_tdata,
  // op
  input  logic [OP_W-1:0]  s_axis_tuser,
  output item_t            head_o,
  output logic             head_vld_o,
  input  logic             pop_i
);

  item_t           in_item;
  logic            push;
  item_t           fifo_q [QDEPTH];
  logic [QPW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]  cnt_q;

  // Unpack the transfer.
  always_comb begin
    in_item.op      = s_axis_tuser;
    in_item.channel = s_axis_tdata[5:0];
    in_item.set_idx = s_axis_tdata[8:6];
    in_item.entry   = s_axis_tdata[17:9];
    in_item.att     = $signed(s_axis_tdata[33:18]);
    in_item.phase   = $signed(s_axis_tdata[49:34]);
    in_item.val_a   = $signed(s_axis_tdata[65:50]);
    in_item.val_b   = $signed(s_axis_tdata[81:66]);
    in_item.bad     = 1'b1;
    case (s_axis_tuser)
      OP_PROC:    in_item.bad = int'(in_item.channel) >= CHANNELS;
      OP_CHAN:    in_item.bad = int'(in_item.set_idx) >= SETS ||
                                int'(in_item.channel) >= CHANNELS;
      OP_ATT,
      OP_PHASE:   in_item.bad = int'(in_item.set_idx) >= SETS ||
                                int'(in_item.entry) >= BREAKPOINTS;
      OP_MAP:     in_item.bad = int'(in_item.set_idx) >= SETS ||
                                int'(in_item.entry) >= MAP_SIZE;
      OP_STRETCH: in_item.bad = int'(in_item.set_idx) >= SETS ||
                                int'(in_item.channel) >= CHANNELS ||
                                int'(in_item.entry) >= ROW_LEN;
      default:    in_item.bad = 1'b1;
    endcase
  end

  assign s_axis_tready = int'(cnt_q) < QDEPTH;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_o        = fifo_q[rd_ptr_q];
  assign head_vld_o    = cnt_q != '0;

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

@@ rtl/core/psc_div.sv @@
// ----------------------------------------------------------------------------
// Calibration divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_div import psc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // One trial subtraction.
  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = !diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (int'(cnt_q) == DVD_W - 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/core/psc_back.sv @@
// ----------------------------------------------------------------------------
// Calibration back end
// Carries out table writes and runs the calibration sequence of a process item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "phase_shifter_calibration_defines.svh"

module psc_back import psc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  item_t             head_i,
  input  logic              head_vld_i,
  output logic              pop_o,
  output div_req_t          div_req_o,
  input  div_rsp_t          div_rsp_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // phase_out, att_out, status
  output logic [OUT_TW-1:0] m_axis_tdata
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CHWT  = 17'h00002,
    S_ASRCH = 17'h00004,
    S_MODST = 17'h00008,
    S_MODWT = 17'h00010,
    S_PSRCH = 17'h00020,
    S_MAPRD = 17'h00040,
    S_MAPWT = 17'h00080,
    S_SSRCH = 17'h00100,
    S_ROW0  = 17'h00200,
    S_ROW1  = 17'h00400,
    S_ROW2  = 17'h00800,
    S_MUL   = 17'h01000,
    S_DIVST = 17'h02000,
    S_DIVWT = 17'h04000,
    S_DONE  = 17'h08000,
    S_OUT   = 17'h10000
  } state_e;

  state_e st_q, st_d;

  // Configuration and count state.
  logic              att_en_q, ph_en_q;
  logic [CFG_DW-1:0] sp_cfg_q;
  logic [BP_CW-1:0]  att_cnt_q [SETS];
  logic [BP_CW-1:0]  ph_cnt_q  [SETS];
  logic [MAP_CW-1:0] map_cnt_q [SETS];
  logic [CHANNELS-1:0] chan_vld_q;

  // Item payload.
  item_t                   it_q;
  logic [SET_IW-1:0]       set_q;
  logic signed [SUM_W-1:0] val_q;
  logic signed [ATT_W-1:0] att_res_q;
  logic [MAP_IW-1:0]       pv_q;
  logic signed [VAL_W-1:0] mval_q;
  logic [SI_W-1:0]         s_idx_q, d_idx_q;
  logic                    d_vld_q;
  logic signed [VAL_W-1:0] prev_bp_q, prev_off_q, r0_q, r1_q;
  logic [ROW_IW-1:0]       pos_q;
  logic signed [VAL_W-1:0] mmin_q, mmax_q, smin_q;
  logic signed [ATT_W-1:0] dv_q, ds_q, span_q;
  logic signed [DVD_W-1:0] prod_q;
  logic                    neg_q;
  logic signed [PH_W-1:0]  res_ph_q;
  logic [STAT_W-1:0]       res_st_q;
  logic                    m_vld_q;
  logic [OUT_TW-1:0]       m_data_q;

  // Memory ports.
  logic                      chan_we, bpt_we, map_we, st_we;
  logic [CH_AW-1:0]          chan_waddr, chan_raddr;
  logic [VAL_W+SET_IW-1:0]   chan_wdata, chan_rd;
  logic [BPT_AW-1:0]         bpt_waddr, bpt_raddr;
  logic [2*VAL_W-1:0]        bpt_wdata, bpt_rd;
  logic [MAP_AW-1:0]         map_waddr, map_raddr;
  logic [VAL_W-1:0]          map_rd;
  logic [ST_AW-1:0]          st_waddr, st_raddr;
  logic [VAL_W-1:0]          st_rd;

  // Helpers.
  logic                    take, wr_ok, srch_state;
  logic [SET_IW-1:0]       hs, ch_set;
  logic signed [VAL_W-1:0] ch_off;
  logic [BP_CW-1:0]        n_bp;
  logic signed [ATT_W-1:0] bs_x, prev_x, cur_x;
  logic signed [VAL_W-1:0] bp_cur, off_cur, bs_res, st_cur;
  logic                    bs_done, ss_hit, ss_end;
  logic [ROW_CW-1:0]       sp;
  logic [MAP_CW-1:0]       n_map, mod_r, pv_n;
  logic [SUM_W-1:0]        val_abs;
  logic [DVD_W-1:0]        prod_abs;
  logic [DVS_W-1:0]        span_abs;
  logic signed [ATT_W-1:0] span_c;
  logic signed [DVD_W:0]   q_s;
  logic signed [DVD_W+1:0] fin_sum;
  logic signed [PH_W-1:0]  fin_ph;
  logic [ST_AW-1:0]        ref_base, row_base;

  assign take       = (st_q == S_IDLE) && head_vld_i;
  assign wr_ok      = take && !head_i.bad;
  assign pop_o      = take;
  assign hs         = head_i.set_idx[SET_IW-1:0];
  assign srch_state = (st_q == S_ASRCH) || (st_q == S_PSRCH) || (st_q == S_SSRCH);

  // Table writes come straight from the queue head.
  assign chan_we    = wr_ok && (head_i.op == OP_CHAN);
  assign chan_waddr = head_i.channel[CH_AW-1:0];
  assign chan_wdata = {hs, head_i.val_a};
  assign chan_raddr = head_i.channel[CH_AW-1:0];

  assign bpt_we    = wr_ok && ((head_i.op == OP_ATT) || (head_i.op == OP_PHASE));
  assign bpt_waddr = BPT_AW'(((head_i.op == OP_PHASE) ? SETS * BREAKPOINTS : 0) +
                             int'(hs) * BREAKPOINTS + int'(head_i.entry[BP_IW-1:0]));
  assign bpt_wdata = {head_i.val_b, head_i.val_a};
  assign bpt_raddr = BPT_AW'(((st_q == S_PSRCH) ? SETS * BREAKPOINTS : 0) +
                             int'(set_q) * BREAKPOINTS + int'(s_idx_q[BP_IW-1:0]));

  assign map_we    = wr_ok && (head_i.op == OP_MAP);
  assign map_waddr = MAP_AW'(int'(hs) * MAP_SIZE + int'(head_i.entry[MAP_IW-1:0]));
  assign map_raddr = MAP_AW'(int'(set_q) * MAP_SIZE + int'(pv_q));

  assign st_we    = wr_ok && (head_i.op == OP_STRETCH);
  assign st_waddr = ST_AW'((int'(hs) * CHANNELS + int'(head_i.channel[CH_AW-1:0])) * ROW_LEN +
                           int'(head_i.entry[ROW_IW-1:0]));
  assign ref_base = ST_AW'(int'(set_q) * CHANNELS * ROW_LEN);
  assign row_base = ST_AW'((int'(set_q) * CHANNELS + int'(it_q.channel[CH_AW-1:0])) *
                           ROW_LEN);

  always_comb begin
    case (st_q)
      S_ROW0:  st_raddr = row_base + ST_AW'(pos_q);
      S_ROW1:  st_raddr = row_base + ST_AW'(pos_q) + ST_AW'(1);
      default: st_raddr = ref_base + ST_AW'(s_idx_q[ROW_IW-1:0]);
    endcase
  end

  psc_ram #(.Width(VAL_W + SET_IW), .Depth(CHANNELS)) u_chan_ram (
    .clk_i, .we_i(chan_we), .waddr_i(chan_waddr), .wdata_i(chan_wdata),
    .raddr_i(chan_raddr), .rdata_o(chan_rd)
  );

  psc_ram #(.Width(2 * VAL_W), .Depth(BPT_DEPTH)) u_bpt_ram (
    .clk_i, .we_i(bpt_we), .waddr_i(bpt_waddr), .wdata_i(bpt_wdata),
    .raddr_i(bpt_raddr), .rdata_o(bpt_rd)
  );

  psc_ram #(.Width(VAL_W), .Depth(MAP_DEPTH)) u_map_ram (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(head_i.val_a),
    .raddr_i(map_raddr), .rdata_o(map_rd)
  );

  psc_ram #(.Width(VAL_W), .Depth(ST_DEPTH)) u_st_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(head_i.val_a),
    .raddr_i(st_raddr), .rdata_o(st_rd)
  );

  // Channel entry; a channel never written reads as offset zero in set zero.
  assign ch_off = chan_vld_q[it_q.channel[CH_AW-1:0]] ? $signed(chan_rd[VAL_W-1:0]) : '0;
  assign ch_set = chan_vld_q[it_q.channel[CH_AW-1:0]] ? chan_rd[VAL_W+SET_IW-1:VAL_W] : '0;

  // Breakpoint search: find the interval holding x, else take the last offset.
  assign n_bp    = (st_q == S_PSRCH) ? ph_cnt_q[set_q] : att_cnt_q[set_q];
  assign bs_x    = (st_q == S_PSRCH) ? $signed(ATT_W'(pv_q)) : ATT_W'(it_q.att);
  assign bp_cur  = $signed(bpt_rd[VAL_W-1:0]);
  assign off_cur = $signed(bpt_rd[2*VAL_W-1:VAL_W]);
  assign prev_x  = ATT_W'(prev_bp_q);
  assign cur_x   = ATT_W'(bp_cur);

  always_comb begin
    bs_done = 1'b0;
    bs_res  = off_cur;
    if (d_vld_q) begin
      if (d_idx_q == '0) begin
        bs_done = (n_bp == BP_CW'(1));
      end else if ((prev_x <= bs_x) && (cur_x > bs_x)) begin
        bs_done = 1'b1;
        bs_res  = prev_off_q;
      end else begin
        bs_done = (int'(d_idx_q) + 1 == int'(n_bp));
      end
    end
  end

  // Stretch position search over the reference row.
  assign sp     = (int'(sp_cfg_q) > STRETCH_MAX) ? ROW_CW'(STRETCH_MAX) : ROW_CW'(sp_cfg_q);
  assign st_cur = $signed(st_rd);
  assign ss_hit = d_vld_q && (d_idx_q != '0) && (prev_bp_q <= mval_q) && (mval_q <= st_cur);
  assign ss_end = d_vld_q && (d_idx_q != '0) && !ss_hit && (int'(d_idx_q) == int'(sp));

  // Wrap of the phase sum into the map range.
  assign n_map   = map_cnt_q[set_q];
  assign val_abs = val_q[SUM_W-1] ? SUM_W'(-val_q) : SUM_W'(val_q);
  assign mod_r   = div_rsp_i.rem[MAP_CW-1:0];
  assign pv_n    = (neg_q && (mod_r != '0)) ? n_map - mod_r : mod_r;

  // Interpolation operands and final saturation.
  assign span_c   = ATT_W'(mmax_q) - ATT_W'(mmin_q);
  assign prod_abs = prod_q[DVD_W-1] ? DVD_W'(-prod_q) : DVD_W'(prod_q);
  assign span_abs = span_q[ATT_W-1] ? DVS_W'(-span_q) : DVS_W'(span_q);
  assign q_s      = neg_q ? -$signed({1'b0, div_rsp_i.quo}) : $signed({1'b0, div_rsp_i.quo});
  assign fin_sum  = (DVD_W+2)'(q_s) + (DVD_W+2)'(smin_q);

  always_comb begin
    if (fin_sum > (DVD_W+2)'(64'sd2147483647)) begin
      fin_ph = 32'sh7fffffff;
    end else if (fin_sum < -(DVD_W+2)'(64'sd2147483648)) begin
      fin_ph = 32'sh80000000;
    end else begin
      fin_ph = fin_sum[PH_W-1:0];
    end
  end

  // Divider requests: wrap first, interpolation later.
  always_comb begin
    div_req_o.start    = ((st_q == S_MODST) && (n_map != '0)) || (st_q == S_DIVST);
    div_req_o.dividend = (st_q == S_DIVST) ? prod_abs : DVD_W'(val_abs);
    div_req_o.divisor  = (st_q == S_DIVST) ? span_abs : DVS_W'(n_map);
  end

  // Sequencer.
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (head_vld_i) begin
          st_d = ((head_i.op == OP_PROC) && !head_i.bad) ? S_CHWT : S_DONE;
        end
      end
      S_CHWT:  st_d = (att_cnt_q[ch_set] == '0) ? S_DONE : (att_en_q ? S_ASRCH : S_MODST);
      S_ASRCH: st_d = bs_done ? S_MODST : S_ASRCH;
      S_MODST: st_d = (n_map == '0) ? S_DONE : S_MODWT;
      S_MODWT: begin
        if (div_rsp_i.done) begin
          st_d = (ph_en_q && (ph_cnt_q[set_q] != '0)) ? S_PSRCH : S_MAPRD;
        end
      end
      S_PSRCH: st_d = bs_done ? S_MAPRD : S_PSRCH;
      S_MAPRD: st_d = S_MAPWT;
      S_MAPWT: st_d = (sp == '0) ? S_DONE : S_SSRCH;
      S_SSRCH: st_d = (ss_hit || ss_end) ? S_ROW0 : S_SSRCH;
      S_ROW0:  st_d = S_ROW1;
      S_ROW1:  st_d = S_ROW2;
      S_ROW2:  st_d = (span_c == '0) ? S_DONE : S_MUL;
      S_MUL:   st_d = S_DIVST;
      S_DIVST: st_d = S_DIVWT;
      S_DIVWT: st_d = div_rsp_i.done ? S_DONE : S_DIVWT;
      S_DONE:  st_d = S_OUT;
      S_OUT:   st_d = (!m_vld_q || m_axis_tready) ? S_IDLE : S_OUT;
      default: st_d = S_IDLE;
    endcase
  end

  // Control state, configuration and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      att_en_q   <= 1'b0;
      ph_en_q    <= 1'b0;
      sp_cfg_q   <= '0;
      chan_vld_q <= '0;
      d_vld_q    <= 1'b0;
      m_vld_q    <= 1'b0;
      for (int i = 0; i < SETS; i++) begin
        att_cnt_q[i] <= '0;
        ph_cnt_q[i]  <= '0;
        map_cnt_q[i] <= '0;
      end
    end else begin
      st_q    <= st_d;
      d_vld_q <= srch_state && (st_d == st_q);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ATT_EN:  att_en_q <= cfg_wdata_i[0];
          CFG_PH_EN:   ph_en_q  <= cfg_wdata_i[0];
          CFG_STRETCH: sp_cfg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (wr_ok) begin
        case (head_i.op)
          OP_CHAN:  chan_vld_q[head_i.channel[CH_AW-1:0]] <= 1'b1;
          OP_ATT: begin
            if (att_cnt_q[hs] < BP_CW'(BREAKPOINTS)) att_cnt_q[hs] <= att_cnt_q[hs] + 1'b1;
          end
          OP_PHASE: begin
            if (ph_cnt_q[hs] < BP_CW'(BREAKPOINTS)) ph_cnt_q[hs] <= ph_cnt_q[hs] + 1'b1;
          end
          OP_MAP: begin
            if (map_cnt_q[hs] < MAP_CW'(MAP_SIZE)) map_cnt_q[hs] <= map_cnt_q[hs] + 1'b1;
          end
          default: ;
        endcase
      end
      if ((st_q == S_OUT) && (!m_vld_q || m_axis_tready)) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (srch_state) begin
      s_idx_q <= s_idx_q + 1'b1;
      d_idx_q <= s_idx_q;
    end else begin
      s_idx_q <= '0;
    end
    case (st_q)
      S_IDLE: begin
        if (head_vld_i) begin
          it_q     <= head_i;
          res_ph_q <= '0;
          res_st_q <= head_i.bad ? ST_IGNORED : ST_OK;
          att_res_q <= (head_i.op == OP_PROC) ? ATT_W'(head_i.att) : '0;
        end
      end
      S_CHWT: begin
        set_q    <= ch_set;
        val_q    <= SUM_W'(it_q.phase) + SUM_W'(ch_off);
        res_st_q <= ST_NO_ATT;
      end
      S_ASRCH: begin
        if (d_vld_q) begin
          prev_bp_q  <= bp_cur;
          prev_off_q <= off_cur;
        end
        if (bs_done) val_q <= val_q + SUM_W'(bs_res);
      end
      S_MODST: begin
        neg_q    <= val_q[SUM_W-1];
        res_st_q <= ST_MAP_EMPTY;
      end
      S_MODWT: begin
        if (div_rsp_i.done) pv_q <= pv_n[MAP_IW-1:0];
      end
      S_PSRCH: begin
        if (d_vld_q) begin
          prev_bp_q  <= bp_cur;
          prev_off_q <= off_cur;
        end
        if (bs_done) att_res_q <= ATT_W'(it_q.att) + ATT_W'(bs_res);
      end
      S_MAPWT: begin
        mval_q   <= $signed(map_rd);
        res_ph_q <= PH_W'($signed(map_rd));
        res_st_q <= ST_OK;
      end
      S_SSRCH: begin
        if (d_vld_q) begin
          prev_bp_q <= st_cur;
          if (d_idx_q == '0) r0_q <= st_cur;
          if (d_idx_q == SI_W'(1)) r1_q <= st_cur;
        end
        if (ss_hit) begin
          pos_q  <= ROW_IW'(d_idx_q - 1'b1);
          mmin_q <= prev_bp_q;
          mmax_q <= st_cur;
        end else if (ss_end) begin
          pos_q  <= '0;
          mmin_q <= r0_q;
          mmax_q <= (d_idx_q == SI_W'(1)) ? st_cur : r1_q;
        end
      end
      S_ROW1: smin_q <= $signed(st_rd);
      S_ROW2: begin
        dv_q   <= ATT_W'(mval_q) - ATT_W'(mmin_q);
        ds_q   <= ATT_W'(st_cur) - ATT_W'(smin_q);
        span_q <= span_c;
        if (span_c == '0) res_st_q <= ST_SPAN_ZERO;
      end
      S_MUL:   prod_q <= dv_q * ds_q;
      S_DIVST: neg_q <= prod_q[DVD_W-1] ^ span_q[ATT_W-1];
      S_DIVWT: begin
        if (div_rsp_i.done) res_ph_q <= fin_ph;
      end
      S_OUT: begin
        if (!m_vld_q || m_axis_tready) begin
          m_data_q <= {{(OUT_TW - PH_W - ATT_W - STAT_W){1'b0}}, res_st_q, att_res_q, res_ph_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  // A search result never points past the loaded breakpoints.
  `PSC_ASSERT(a_srch_idx, ((st_q == S_ASRCH || st_q == S_PSRCH) && d_vld_q) |-> (int'(d_idx_q) < int'(n_bp)), "breakpoint search ran past the count")
  // The wrapped phase stays inside the map.
  `PSC_ASSERT(a_phase_idx, (st_q == S_PSRCH || st_q == S_MAPRD) |-> (MAP_CW'(pv_q) < n_map), "wrapped phase outside the map")
  // The divider only answers while the sequencer waits for it.
  `PSC_ASSERT(a_div_wait, div_rsp_i.done |-> (st_q == S_MODWT || st_q == S_DIVWT), "unexpected divider result")
  // Interpolation never divides by a zero span.
  `PSC_ASSERT_NEVER(a_span_zero, (st_q == S_DIVST) && (span_q == '0), "division by zero span")

endmodule
